[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define CHK_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked on every edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

[src/ite_pkg.sv]
// ---------------------------------------------------------------------------
// ite_pkg
// Types and constants of the interval timer emulation.
// ---------------------------------------------------------------------------
package ite_pkg;

  localparam int IDX_W      = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS  = 32;

  // access phases
  localparam logic [2:0] PH_LSB      = 3'd1;
  localparam logic [2:0] PH_MSB      = 3'd2;
  localparam logic [2:0] PH_LSB_NEXT = 3'd3;
  localparam logic [2:0] PH_MSB_NEXT = 3'd4;

  // actions
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_CTRL  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  // count modes
  localparam logic [2:0] MODE_ONESHOT = 3'd0;
  localparam logic [2:0] MODE_RATE    = 3'd2;
  localparam logic [2:0] MODE_SQUARE  = 3'd3;
  localparam logic [2:0] MODE_STROBE  = 3'd4;
  localparam logic [2:0] MODE_LAST    = 3'd5;

  localparam logic [1:0]  CTRL_RDBACK  = 2'd3;
  localparam logic [1:0]  ACC_LATCH    = 2'd0;
  localparam logic [16:0] ZERO_BIN     = 17'h10000;
  localparam logic [16:0] ZERO_BCD     = 17'd9999;
  localparam logic [10:0] USEC_TO_CNT  = 11'd1193;
  localparam logic [9:0]  CNT_TO_USEC  = 10'd1000;
  localparam logic [15:0] COUNT_FULL   = 16'hFFFF;
  localparam logic [7:0]  BAD_READ     = 8'hFF;

  // x / 1000 and x / 1193 as (x * recip) >> RECIP_SHIFT, exact for x < 2^27
  localparam int          RECIP_SHIFT   = 37;
  localparam logic [27:0] DIV1000_RECIP = 28'd137438954;
  localparam logic [27:0] DIV1193_RECIP = 28'd115204488;

  localparam logic [2:0]  RST_PHASE  [3] = '{3'd3, 3'd1, 3'd3};
  localparam logic [2:0]  RST_MODE   [3] = '{3'd3, 3'd2, 3'd3};
  localparam logic [15:0] RST_PERIOD [3] = '{16'd54933, 16'd15, 16'd1106};

  typedef enum logic [2:0] {
    K_NOP   = 3'd0,
    K_READ  = 3'd1,
    K_RBAD  = 3'd2,
    K_WRITE = 3'd3,
    K_LATCH = 3'd4,
    K_PROG  = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
    logic [31:0]      now;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] rem;
  } div_rsp_t;

endpackage

[src/ite_front.sv]
// ---------------------------------------------------------------------------
// ite_front
// Unpacks bus accesses and sorts them into operation kinds.
// ---------------------------------------------------------------------------
module ite_front import ite_pkg::*; #(
  parameter int NUM_COUNTERS = 3
) (
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        full,
  output logic        push,
  output item_t       item
);

  logic [1:0] action;
  logic [1:0] cnt;
  logic [1:0] csel;
  logic [7:0] data;

  assign action   = s_tdata[1:0];
  assign cnt      = s_tdata[3:2];
  assign data     = s_tdata[11:4];
  assign csel     = data[7:6];
  assign s_tready = !full;
  assign push     = s_tvalid && !full;

  always_comb begin
    item.data = data;
    item.now  = s_tdata[43:12];
    item.idx  = cnt;
    item.kind = K_NOP;
    case (action)
      ACT_READ: begin
        item.kind = (32'(cnt) < NUM_COUNTERS) ? K_READ : K_RBAD;
      end
      ACT_WRITE: begin
        if (32'(cnt) < NUM_COUNTERS) item.kind = K_WRITE;
      end
      ACT_CTRL: begin
        item.idx = csel;
        if (csel != CTRL_RDBACK && 32'(csel) < NUM_COUNTERS) begin
          item.kind = (data[5:4] == ACC_LATCH) ? K_LATCH : K_PROG;
        end
      end
      default: item.kind = K_NOP;
    endcase
  end

endmodule

[src/ite_queue.sv]
// ---------------------------------------------------------------------------
// ite_queue
// Short FIFO between the front and the back.
// ---------------------------------------------------------------------------
module ite_queue import ite_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  not_empty,
  output item_t head
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t         mem [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   fill;

  assign full      = (fill == (PW+1)'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

[src/ite_div.sv]
// ---------------------------------------------------------------------------
// ite_div
// Restoring divider, 32-bit dividend by 17-bit divisor, one bit per cycle.
// ---------------------------------------------------------------------------
module ite_div import ite_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CW = $clog2(DIV_STEPS);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [31:0]   quo;
  logic [16:0]   rem;
  logic [16:0]   dvs;
  logic          done;
  logic [17:0]   sh;
  logic [18:0]   diff;
  logic          ge;

  assign sh   = {rem, quo[31]};
  assign diff = {1'b0, sh} - {2'b0, dvs};
  assign ge   = !diff[18];

  assign rsp.done = done;
  assign rsp.rem  = rem;

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[30:0], ge};
      rem <= ge ? diff[16:0] : sh[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/ite_back.sv]
// ---------------------------------------------------------------------------
// ite_back
// Counter state, operation sequencer and result register.
// ---------------------------------------------------------------------------
module ite_back import ite_pkg::*; #(
  parameter int NUM_COUNTERS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  item_t       qi,
  output logic        pop,
  output div_req_t    dreq,
  input  div_rsp_t    drsp,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata
);

  localparam int IW = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MOD  = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_SCL  = 7'b0001000,
    S_SCLW = 7'b0010000,
    S_OUT  = 7'b0100000,
    S_HOLD = 7'b1000000
  } state_t;

  state_t state;

  logic        bcd     [NUM_COUNTERS];
  logic [2:0]  phase   [NUM_COUNTERS];
  logic [2:0]  mode    [NUM_COUNTERS];
  logic        run     [NUM_COUNTERS];
  logic [15:0] latched [NUM_COUNTERS];
  logic [16:0] reload  [NUM_COUNTERS];
  logic [15:0] rusec   [NUM_COUNTERS];
  logic [31:0] ltime   [NUM_COUNTERS];

  logic [IW-1:0] idx_r;
  logic          zero_idx;
  logic [31:0]   d_r;
  logic [15:0]   v_r;
  logic [26:0]   prod;
  logic [15:0]   scl_r;
  logic          lat_r;
  logic [7:0]    rd_r;
  logic          chg_r;
  logic [15:0]   per_r;

  logic [IW-1:0] sel;
  logic [31:0]   d_c;
  logic [31:0]   a_c;
  logic          mode_ok;
  logic [16:0]   nr;
  logic [16:0]   rv_fin;
  logic          wr_done;
  logic [2:0]    ph_next;
  logic [2:0]    m_prog;
  logic [15:0]   mrem;
  logic [54:0]   scl_prod;

  assign sel = (state == S_IDLE) ? qi.idx[IW-1:0] : idx_r;
  assign pop = (state == S_IDLE) && q_valid;

  assign d_c = qi.now - ltime[sel];
  assign a_c = 32'(rusec[sel]) + 32'(latched[sel])
             - ((mode[sel] == MODE_SQUARE) ? {d_c[30:0], 1'b0} : d_c);
  assign mode_ok = (mode[sel] == MODE_ONESHOT) || (mode[sel] == MODE_RATE) ||
                   (mode[sel] == MODE_SQUARE) || (mode[sel] == MODE_STROBE);
  assign m_prog = (qi.data[3:1] > MODE_LAST) ? qi.data[3:1] - 3'd4 : qi.data[3:1];
  assign mrem = (rusec[sel] == '0) ? '0 : drsp.rem[15:0];

  // constant division by reciprocal multiply
  assign scl_prod = 55'(prod) * 55'(lat_r ? DIV1000_RECIP : DIV1193_RECIP);

  // write-path reload assembly
  always_comb begin
    nr      = reload[sel];
    wr_done = 1'b1;
    ph_next = phase[sel];
    case (phase[sel])
      PH_LSB: nr = {9'b0, qi.data};
      PH_MSB: nr = {1'b0, qi.data, 8'b0};
      PH_LSB_NEXT: begin
        nr      = {9'b0, qi.data};
        wr_done = 1'b0;
        ph_next = PH_MSB_NEXT;
      end
      PH_MSB_NEXT: begin
        nr      = reload[sel] | {1'b0, qi.data, 8'b0};
        ph_next = PH_LSB_NEXT;
      end
      default: nr = reload[sel];
    endcase
    rv_fin = nr;
    if (nr == '0) rv_fin = bcd[sel] ? ZERO_BCD : ZERO_BIN;
  end

  // only the latch modulo uses the divider
  always_comb begin
    dreq.start    = (state == S_IDLE) && q_valid && (qi.kind == K_LATCH) &&
                    run[sel] && mode_ok;
    dreq.dividend = a_c;
    dreq.divisor  = {1'b0, rusec[sel]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        bcd[i]     <= 1'b0;
        phase[i]   <= RST_PHASE[i];
        mode[i]    <= RST_MODE[i];
        run[i]     <= 1'b1;
        latched[i] <= RST_PERIOD[i];
        reload[i]  <= '0;
        rusec[i]   <= RST_PERIOD[i];
        ltime[i]   <= '0;
      end
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            idx_r    <= qi.idx[IW-1:0];
            zero_idx <= (qi.idx == '0);
            chg_r    <= 1'b0;
            per_r    <= '0;
            case (qi.kind)
              K_RBAD: begin
                rd_r  <= BAD_READ;
                state <= S_OUT;
              end
              K_READ: begin
                state <= S_OUT;
                case (phase[sel])
                  PH_LSB: rd_r <= latched[sel][7:0];
                  PH_MSB: rd_r <= latched[sel][15:8];
                  PH_LSB_NEXT: begin
                    rd_r       <= latched[sel][7:0];
                    phase[sel] <= PH_MSB_NEXT;
                  end
                  PH_MSB_NEXT: begin
                    rd_r       <= latched[sel][15:8];
                    phase[sel] <= PH_LSB_NEXT;
                  end
                  default: rd_r <= BAD_READ;
                endcase
              end
              K_WRITE: begin
                rd_r       <= '0;
                phase[sel] <= ph_next;
                if (wr_done) begin
                  reload[sel] <= rv_fin;
                  prod        <= 27'(rv_fin) * 27'(CNT_TO_USEC);
                  lat_r       <= 1'b0;
                  state       <= S_SCL;
                end else begin
                  reload[sel] <= nr;
                  state       <= S_OUT;
                end
              end
              K_LATCH: begin
                rd_r       <= '0;
                bcd[sel]   <= qi.data[0];
                ltime[sel] <= qi.now;
                d_r        <= d_c;
                if (run[sel] && mode_ok) begin
                  state <= S_MOD;
                end else begin
                  state <= S_OUT;
                  if (run[sel]) latched[sel] <= COUNT_FULL;
                end
              end
              K_PROG: begin
                rd_r       <= '0;
                bcd[sel]   <= qi.data[0];
                phase[sel] <= {1'b0, qi.data[5:4]};
                mode[sel]  <= m_prog;
                run[sel]   <= 1'b1;
                state      <= S_OUT;
              end
              default: begin
                rd_r  <= '0;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_MOD: begin
          if (drsp.done) begin
            lat_r <= 1'b1;
            state <= S_MUL;
            if (mode[sel] == MODE_SQUARE) begin
              v_r <= {mrem[15:1], 1'b0};
            end else if (mode[sel] != MODE_RATE && d_r > 32'(mrem)) begin
              run[sel] <= 1'b0;
              v_r      <= '0;
            end else begin
              v_r <= mrem;
            end
          end
        end
        S_MUL: begin
          prod  <= 27'(v_r) * 27'(USEC_TO_CNT);
          state <= S_SCL;
        end
        S_SCL: begin
          scl_r <= scl_prod[RECIP_SHIFT+15:RECIP_SHIFT];
          state <= S_SCLW;
        end
        S_SCLW: begin
          state <= S_OUT;
          if (lat_r) begin
            latched[sel] <= scl_r;
          end else begin
            rusec[sel] <= scl_r;
            if (zero_idx) begin
              chg_r <= 1'b1;
              per_r <= scl_r;
            end
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {7'b0, per_r, chg_r, rd_r};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/interval_timer_emulation.sv]
// ---------------------------------------------------------------------------
// interval_timer_emulation
// Three-counter 8253-style timer model driven by bus access items.
// ---------------------------------------------------------------------------
// Usage:
//  - s_* channel takes one access item: a counter read, a counter write or a
//    control word, stamped with a 32-bit microsecond time.
//  - m_* channel returns exactly one result item per access, in order.
//  - Front classifies items into a 2-entry queue; the back sequencer executes
//    them one at a time against the per-counter state.
//  - Back states per item: reads, control words and partial writes go from
//    S_IDLE to S_OUT; a completed write adds S_SCL, S_SCLW (1000/1193 scale
//    by reciprocal multiply); a latch of a running counter in modes 0, 2, 3, 4
//    adds S_MOD (the 32-step one-bit-per-cycle modulo by the period), S_MUL,
//    S_SCL, S_SCLW (the 1193/1000 rescale) before S_OUT.
//  - S_OUT loads the result register; the next item starts the cycle after.
//  - Reset (rst, synchronous) restores the power-up counter state, empties
//    the queue and drops m_tvalid.
//  - A stalled receiver holds the result register; the back then stalls,
//    the queue fills and s_tready drops after two more items.
// ---------------------------------------------------------------------------
module interval_timer_emulation import ite_pkg::*; #(
  parameter int NUM_COUNTERS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] action, [3:2] counter, [11:4] data, [43:12] now_usec, rest zero
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] read_data, [8] period_changed, [24:9] new_period_usec, rest zero
  output logic [31:0] m_tdata
);

  logic     full;
  logic     push;
  logic     pop;
  logic     q_valid;
  item_t    in_item;
  item_t    head;
  div_req_t dreq;
  div_rsp_t drsp;

  ite_front #(.NUM_COUNTERS(NUM_COUNTERS)) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .full     (full),
    .push     (push),
    .item     (in_item)
  );

  ite_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (in_item),
    .pop       (pop),
    .full      (full),
    .not_empty (q_valid),
    .head      (head)
  );

  ite_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  ite_back #(.NUM_COUNTERS(NUM_COUNTERS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .qi       (head),
    .pop      (pop),
    .dreq     (dreq),
    .drsp     (drsp),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[src/ite_checker.sv]
// ---------------------------------------------------------------------------
// ite_checker
// Port-level checks of the interval timer emulation.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ite_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // result held while stalled
  `CHK_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> m_tvalid)
  // no result right after reset
  `CHK_ASSERT_ALWAYS(a_rst_quiet, clk, rst |=> !m_tvalid)
  // period is zero unless flagged
  `CHK_ASSERT(a_per_flag, clk, rst, (m_tvalid && !m_tdata[8]) |-> (m_tdata[24:9] == 16'd0))
  // a period report never carries read data
  `CHK_ASSERT(a_kind_excl, clk, rst, (m_tvalid && m_tdata[8]) |-> (m_tdata[7:0] == 8'd0))
  // padding stays clear
  `CHK_ASSERT(a_pad_zero, clk, rst, m_tvalid |-> (m_tdata[31:25] == 7'd0))

endmodule

bind interval_timer_emulation ite_checker u_ite_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
